// File: hw/rtl/assert_macros.svh
// Assertion macros used by the evaluator top level for its checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/rpn_pkg.sv
// Shared constants and codes for the postfix stack evaluator.
`default_nettype none

package rpn_pkg;

    // Stack geometry and number format
    localparam int STACK_DEPTH = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);

    // Quotient magnitude width and divider stepping (two bits per cycle)
    localparam int QUO_W       = VALUE_WIDTH + FRAC_BITS;
    localparam int DIV_STEPS   = QUO_W / 2;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    // Stream word layout
    localparam int IN_USER_W   = 3;
    localparam int OUT_USER_W  = 3;
    localparam int OUT_DATA_W  = ((VALUE_WIDTH + DEPTH_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_DATA_W - VALUE_WIDTH - DEPTH_W;

    // Token kinds
    typedef enum logic [2:0] {
        ACT_PUSH = 3'd0,
        ACT_ADD  = 3'd1,
        ACT_SUB  = 3'd2,
        ACT_MUL  = 3'd3,
        ACT_DIV  = 3'd4
    } t_action;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_FULL      = 2'd2,
        ST_DIV_ZERO  = 2'd3
    } t_status;

endpackage

`default_nettype wire

// File: hw/rtl/rpn_stack_evaluator.sv
// Top level of the postfix stack evaluator: token sequencer, stack memory, arithmetic.
//
//  channel   dir  tdata                                  tuser
//  s_axis    in   [31:0] operand_value                   [2:0] action
//  m_axis    out  [31:0] top_value, [38:32] stack_depth  [1:0] status, [2] saturated
//
// One token at a time; s_axis_tready is high only while the sequencer is idle.
// Push, add, subtract and errors: S_EXEC, S_DONE; multiply adds S_MUL, S_MULF; divide
// waits in S_DIV on the two-bit-per-cycle divider (24 steps for 48 quotient bits).
// The stack lives in a 64-entry memory with a registered read port; the top entry is
// also kept in a register so each operator needs a single memory read.
// Reset (i_rst_n low, synchronous) empties the stack; memory contents are not cleared.
// A result waiting on m_axis holds the next token's commit, not its acceptance.
`default_nettype none

module rpn_stack_evaluator (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input tokens
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [rpn_pkg::VALUE_WIDTH-1:0]   s_axis_tdata,  // [31:0] operand_value
    input  wire logic [rpn_pkg::IN_USER_W-1:0]     s_axis_tuser,  // [2:0] action
    // results
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [rpn_pkg::OUT_DATA_W-1:0]         m_axis_tdata,  // [31:0] top_value,
                                                                  // [38:32] stack_depth
    output logic [rpn_pkg::OUT_USER_W-1:0]         m_axis_tuser   // [1:0] status,
                                                                  // [2] saturated
);

    localparam int VW = rpn_pkg::VALUE_WIDTH;
    localparam int DW = rpn_pkg::DEPTH_W;
    localparam int AW = rpn_pkg::ADDR_W;
    localparam int QW = rpn_pkg::QUO_W;
    localparam logic [VW-1:0] VMAX   = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] VMIN   = {1'b1, {(VW-1){1'b0}}};
    localparam logic [DW-1:0] D_ONE  = DW'(1);
    localparam logic [DW-1:0] D_TWO  = DW'(2);
    localparam logic [DW-1:0] D_FULL = DW'(rpn_pkg::STACK_DEPTH);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_MUL  = 6'b000100,
        S_MULF = 6'b001000,
        S_DIV  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    // Apply sign to a magnitude and clamp to range: returns {sat, value}
    function automatic logic [VW:0] sign_clamp(input logic neg, input logic [QW-1:0] m);
        logic [QW-1:0] lim;
        lim = QW'(VMAX) + QW'(neg);
        if (m > lim) begin
            return {1'b1, neg ? VMIN : VMAX};
        end
        return {1'b0, neg ? (VW'(0) - m[VW-1:0]) : m[VW-1:0]};
    endfunction

    t_state                r_state, n_state;
    logic [DW-1:0]         r_count, n_count;
    logic [VW-1:0]         r_top, n_top;
    logic [2:0]            r_action;
    logic [VW-1:0]         r_operand;
    logic [VW-1:0]         r_rd;
    logic [VW-1:0]         r_res, n_res;
    rpn_pkg::t_status      r_status, n_status;
    logic                  r_sat, n_sat;
    logic                  r_push, n_push;
    logic                  r_pop, n_pop;
    logic [VW-1:0]         r_mag_a, n_mag_a;
    logic [VW-1:0]         r_mag_b, n_mag_b;
    logic                  r_neg, n_neg;
    logic [2*VW-1:0]       r_prod;
    logic                  r_out_valid, n_out_valid;
    logic [VW-1:0]         r_out_top, n_out_top;
    logic [DW-1:0]         r_out_depth, n_out_depth;
    rpn_pkg::t_status      r_out_status, n_out_status;
    logic                  r_out_sat, n_out_sat;

    logic                  accept;
    logic                  commit;
    logic [DW-1:0]         count_m2;
    logic                  mem_we;
    logic [AW-1:0]         mem_wa;
    logic [VW-1:0]         stack_mem [rpn_pkg::STACK_DEPTH];
    logic [VW:0]           sum_ext, diff_ext;
    logic [VW-1:0]         mag_sec, mag_top;
    logic                  div_start, div_done;
    logic [QW-1:0]         div_quo;
    logic [VW:0]           mul_fin, div_fin;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign commit        = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);
    assign count_m2      = r_count - D_TWO;

    // Operand preparation: second entry comes from memory, top from its register
    assign sum_ext  = {r_rd[VW-1], r_rd} + {r_top[VW-1], r_top};
    assign diff_ext = {r_rd[VW-1], r_rd} - {r_top[VW-1], r_top};
    assign mag_sec  = r_rd[VW-1]  ? (VW'(0) - r_rd)  : r_rd;
    assign mag_top  = r_top[VW-1] ? (VW'(0) - r_top) : r_top;
    assign mul_fin  = sign_clamp(r_neg, r_prod[2*VW-1:rpn_pkg::FRAC_BITS]);
    assign div_fin  = sign_clamp(r_neg, div_quo);

    // Stack memory: one write port, one registered read port
    assign mem_we = commit && (r_push || r_pop);
    assign mem_wa = r_push ? r_count[AW-1:0] : count_m2[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            stack_mem[mem_wa] <= r_res;
        end
        if (accept) begin
            r_rd <= stack_mem[count_m2[AW-1:0]];
        end
    end

    // Divider for the divide token
    rpn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mag_sec),
        .i_divisor  (mag_top),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Sequencer and next-value logic
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_top        = r_top;
        n_res        = r_res;
        n_status     = r_status;
        n_sat        = r_sat;
        n_push       = r_push;
        n_pop        = r_pop;
        n_mag_a      = r_mag_a;
        n_mag_b      = r_mag_b;
        n_neg        = r_neg;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_top    = r_out_top;
        n_out_depth  = r_out_depth;
        n_out_status = r_out_status;
        n_out_sat    = r_out_sat;
        div_start    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_res    = r_top;
                n_status = rpn_pkg::ST_OK;
                n_sat    = 1'b0;
                n_push   = 1'b0;
                n_pop    = 1'b0;
                n_neg    = r_rd[VW-1] ^ r_top[VW-1];
                n_mag_a  = mag_sec;
                n_mag_b  = mag_top;
                n_state  = S_DONE;
                priority if (r_action == rpn_pkg::ACT_PUSH) begin
                    if (r_count >= D_FULL) begin
                        n_status = rpn_pkg::ST_FULL;
                    end else begin
                        n_res  = r_operand;
                        n_push = 1'b1;
                    end
                end else if (r_action > rpn_pkg::ACT_DIV) begin
                    // unused codes leave everything as it is
                    n_status = rpn_pkg::ST_OK;
                end else if (r_count < D_TWO) begin
                    n_status = rpn_pkg::ST_UNDERFLOW;
                end else if (r_action == rpn_pkg::ACT_ADD) begin
                    n_pop = 1'b1;
                    if (sum_ext[VW] != sum_ext[VW-1]) begin
                        n_sat = 1'b1;
                        n_res = sum_ext[VW] ? VMIN : VMAX;
                    end else begin
                        n_res = sum_ext[VW-1:0];
                    end
                end else if (r_action == rpn_pkg::ACT_SUB) begin
                    n_pop = 1'b1;
                    if (diff_ext[VW] != diff_ext[VW-1]) begin
                        n_sat = 1'b1;
                        n_res = diff_ext[VW] ? VMIN : VMAX;
                    end else begin
                        n_res = diff_ext[VW-1:0];
                    end
                end else if (r_action == rpn_pkg::ACT_MUL) begin
                    n_state = S_MUL;
                end else if (r_top == '0) begin
                    n_status = rpn_pkg::ST_DIV_ZERO;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end

            S_MUL: begin
                n_state = S_MULF;
            end

            S_MULF: begin
                n_pop   = 1'b1;
                n_sat   = mul_fin[VW];
                n_res   = mul_fin[VW-1:0];
                n_state = S_DONE;
            end

            S_DIV: begin
                if (div_done) begin
                    n_pop   = 1'b1;
                    n_sat   = div_fin[VW];
                    n_res   = div_fin[VW-1:0];
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (commit) begin
                    if (r_push) begin
                        n_count = r_count + D_ONE;
                        n_top   = r_res;
                    end else if (r_pop) begin
                        n_count = r_count - D_ONE;
                        n_top   = r_res;
                    end
                    n_out_valid  = 1'b1;
                    n_out_top    = (n_count != '0) ? n_top : '0;
                    n_out_depth  = n_count;
                    n_out_status = r_status;
                    n_out_sat    = r_sat;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action  <= s_axis_tuser;
            r_operand <= s_axis_tdata;
        end
        if (r_state == S_MUL) begin
            r_prod <= r_mag_a * r_mag_b;
        end
        r_top        <= n_top;
        r_res        <= n_res;
        r_status     <= n_status;
        r_sat        <= n_sat;
        r_push       <= n_push;
        r_pop        <= n_pop;
        r_mag_a      <= n_mag_a;
        r_mag_b      <= n_mag_b;
        r_neg        <= n_neg;
        r_out_top    <= n_out_top;
        r_out_depth  <= n_out_depth;
        r_out_status <= n_out_status;
        r_out_sat    <= n_out_sat;
    end

    // Result word
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{rpn_pkg::OUT_PAD_W{1'b0}}, r_out_depth, r_out_top};
    assign m_axis_tuser  = {r_out_sat, r_out_status};

    // Checks
`include "assert_macros.svh"

    `ASSERT_IMPLIES(a_depth_bound, i_clk, i_rst_n, 1'b1, r_count <= D_FULL, "stack depth out of range")
    `ASSERT_NEXT(a_idle_holds_count, i_clk, i_rst_n, r_state == S_IDLE, $stable(r_count), "depth changed while idle")
    `ASSERT_IMPLIES(a_div_done_owner, i_clk, i_rst_n, div_done, r_state == S_DIV, "divider finished outside divide")
    `ASSERT_NEXT(a_error_keeps_stack, i_clk, i_rst_n, commit && (r_status != rpn_pkg::ST_OK), $stable(r_count), "error token changed depth")

endmodule

`default_nettype wire

// File: hw/rtl/rpn_div.sv
// Unsigned restoring divider for fixed-point quotients, two bits per cycle.
`default_nettype none

module rpn_div (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [rpn_pkg::VALUE_WIDTH-1:0] i_dividend,
    input  wire logic [rpn_pkg::VALUE_WIDTH-1:0] i_divisor,
    output logic                                 o_done,
    output logic [rpn_pkg::QUO_W-1:0]            o_quotient
);

    localparam int VW = rpn_pkg::VALUE_WIDTH;
    localparam int QW = rpn_pkg::QUO_W;
    localparam int CW = rpn_pkg::DIV_CNT_W;
    localparam logic [CW-1:0] LAST_STEP = CW'(rpn_pkg::DIV_STEPS - 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [QW-1:0] r_num;   // numerator bits leave at the top, quotient bits enter at the bottom
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_den;

    logic [VW:0]   t1, t2, rem1, rem2;
    logic          ge1, ge2;

    // Two dependent shift-subtract steps
    always_comb begin
        t1   = {r_rem, r_num[QW-1]};
        ge1  = (t1 >= {1'b0, r_den});
        rem1 = ge1 ? (t1 - {1'b0, r_den}) : t1;
        t2   = {rem1[VW-1:0], r_num[QW-2]};
        ge2  = (t2 >= {1'b0, r_den});
        rem2 = ge2 ? (t2 - {1'b0, r_den}) : t2;
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {i_dividend, {rpn_pkg::FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[QW-3:0], ge1, ge2};
            r_rem <= rem2[VW-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_num;

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the postfix stack evaluator.
`timescale 1ns / 1ps

module testbench;

    // Reserved token kinds; the block leaves the stack unchanged for them
    localparam logic [2:0] ACT_RSV5 = 3'd5;
    localparam logic [2:0] ACT_RSV6 = 3'd6;
    localparam logic [2:0] ACT_RSV7 = 3'd7;

    // Q16.16 constants
    localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN     = 32'h8000_0000;
    localparam logic [31:0] Q_ONE     = 32'h0001_0000;
    localparam logic [31:0] Q_HALF    = 32'h0000_8000;
    localparam logic [31:0] Q_NEG_ONE = 32'hFFFF_0000;

    localparam int STALL_LIMIT = 5000;   // cycles without any accepted word
    localparam int HOLD_CYCLES = 400;    // long receiver hold-off
    localparam int DRAIN_WAIT  = 64;     // extra settle time after the final drain

    typedef struct {
        logic [31:0]                 top;
        logic [rpn_pkg::DEPTH_W-1:0] depth;
        rpn_pkg::t_status            status;
        logic                        sat;
    } t_stack_readout;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [rpn_pkg::VALUE_WIDTH-1:0] s_axis_tdata = '0;  // [31:0] operand_value
    logic [rpn_pkg::IN_USER_W-1:0] s_axis_tuser = '0;    // [2:0] action
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [rpn_pkg::OUT_DATA_W-1:0] m_axis_tdata;  // [31:0] top_value, [38:32] stack_depth
    logic [rpn_pkg::OUT_USER_W-1:0] m_axis_tuser;  // [1:0] status, [2] saturated

    // Shadow copy of the stack, updated on every accepted token
    logic [31:0] shadow_stack [rpn_pkg::STACK_DEPTH];
    int shadow_depth = 0;
    t_stack_readout pending_readouts [$];

    // Idling controls
    bit sender_steady = 1'b0;
    bit sink_steady = 1'b0;
    int sink_hold_req = 0;

    // Tallies
    int mismatch_count = 0;
    int results_checked = 0;
    int action_tally [8];
    int status_tally [4];
    int sat_tally = 0;
    int peak_depth = 0;
    int idle_cycles = 0;

    rpn_stack_evaluator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic void log_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("ERROR @%0t: %s", $time, msg);
    endfunction

    // Mostly no gap, some short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Sign a magnitude and clamp to Q16.16; bit 32 flags saturation
    function automatic logic [32:0] signed_clamp(input logic neg, input logic [63:0] m);
        logic [63:0] lim;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (m > lim) return {1'b1, neg ? Q_MIN : Q_MAX};
        return {1'b0, neg ? 32'(64'd0 - m) : m[31:0]};
    endfunction

    // Q16.16 arithmetic: second (lhs) op top (rhs); rhs nonzero for divide
    function automatic logic [32:0] fixed_arith(input logic [2:0] act,
                                                input logic [31:0] lhs,
                                                input logic [31:0] rhs);
        logic signed [63:0] wide;
        logic [63:0] lmag, rmag, m;
        logic neg;
        lmag = lhs[31] ? (64'd0 - {{32{1'b1}}, lhs}) : {32'd0, lhs};
        rmag = rhs[31] ? (64'd0 - {{32{1'b1}}, rhs}) : {32'd0, rhs};
        neg  = lhs[31] ^ rhs[31];
        case (act)
            rpn_pkg::ACT_ADD, rpn_pkg::ACT_SUB: begin
                if (act == rpn_pkg::ACT_ADD)
                    wide = $signed({{32{lhs[31]}}, lhs}) + $signed({{32{rhs[31]}}, rhs});
                else
                    wide = $signed({{32{lhs[31]}}, lhs}) - $signed({{32{rhs[31]}}, rhs});
                m = wide[63] ? (64'd0 - wide) : wide;
                return signed_clamp(wide[63], m);
            end
            rpn_pkg::ACT_MUL: begin
                // magnitude truncation rounds toward zero
                m = (lmag * rmag) >> rpn_pkg::FRAC_BITS;
                return signed_clamp(neg, m);
            end
            default: begin
                m = (lmag << rpn_pkg::FRAC_BITS) / rmag;
                return signed_clamp(neg, m);
            end
        endcase
    endfunction

    // Apply one accepted token to the shadow stack and queue its readout
    function automatic void eval_token(input logic [2:0] act, input logic [31:0] val);
        t_stack_readout r;
        logic [31:0] lhs, rhs;
        logic [32:0] res;
        r.status = rpn_pkg::ST_OK;
        r.sat = 1'b0;
        case (act)
            rpn_pkg::ACT_PUSH: begin
                if (shadow_depth >= rpn_pkg::STACK_DEPTH) begin
                    r.status = rpn_pkg::ST_FULL;
                end else begin
                    shadow_stack[shadow_depth] = val;
                    shadow_depth++;
                end
            end
            rpn_pkg::ACT_ADD, rpn_pkg::ACT_SUB, rpn_pkg::ACT_MUL, rpn_pkg::ACT_DIV: begin
                if (shadow_depth < 2) begin
                    r.status = rpn_pkg::ST_UNDERFLOW;
                end else begin
                    rhs = shadow_stack[shadow_depth-1];
                    lhs = shadow_stack[shadow_depth-2];
                    if (act == rpn_pkg::ACT_DIV && rhs == '0) begin
                        r.status = rpn_pkg::ST_DIV_ZERO;
                    end else begin
                        res = fixed_arith(act, lhs, rhs);
                        r.sat = res[32];
                        shadow_depth--;
                        shadow_stack[shadow_depth-1] = res[31:0];
                    end
                end
            end
            default: ;  // reserved kinds leave the stack alone
        endcase
        r.top = (shadow_depth > 0) ? shadow_stack[shadow_depth-1] : '0;
        r.depth = rpn_pkg::DEPTH_W'(shadow_depth);
        pending_readouts.push_back(r);
        action_tally[act]++;
        status_tally[r.status]++;
        if (r.sat) sat_tally++;
        if (shadow_depth > peak_depth) peak_depth = shadow_depth;
    endfunction

    function automatic logic [2:0] pick_operator();
        case ($urandom_range(0, 3))
            0: return rpn_pkg::ACT_ADD;
            1: return rpn_pkg::ACT_SUB;
            2: return rpn_pkg::ACT_MUL;
            default: return rpn_pkg::ACT_DIV;
        endcase
    endfunction

    // Mix of zero, extremes, full-range and small values
    function automatic logic [31:0] random_operand();
        case ($urandom_range(0, 9))
            0: return '0;
            1: begin
                case ($urandom_range(0, 3))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return Q_ONE;
                    default: return Q_NEG_ONE;
                endcase
            end
            2, 3: return $urandom();
            default: return 32'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000;
        endcase
    endfunction

    // Well-formed expressions mostly; depth steers push versus operator
    function automatic void next_random_token(output logic [2:0] act, output logic [31:0] val);
        int push_pct;
        val = random_operand();
        if ($urandom_range(0, 99) < 4) begin
            case ($urandom_range(0, 2))
                0: act = ACT_RSV5;
                1: act = ACT_RSV6;
                default: act = ACT_RSV7;
            endcase
            return;
        end
        if (shadow_depth < 2) push_pct = 85;
        else if (shadow_depth >= rpn_pkg::STACK_DEPTH - 4) push_pct = 15;
        else if (shadow_depth > 40) push_pct = 35;
        else push_pct = 55;
        act = ($urandom_range(0, 99) < push_pct) ? rpn_pkg::ACT_PUSH : pick_operator();
    endfunction

    // Offer one token and wait for it to be taken; called at a clock edge
    task automatic send_token(input logic [2:0] act, input logic [31:0] val);
        int gap;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        s_axis_tuser  <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        eval_token(act, val);
    endtask

    task automatic send_random(input int count);
        logic [2:0] act;
        logic [31:0] val;
        repeat (count) begin
            next_random_token(act, val);
            send_token(act, val);
        end
    endtask

    // Drop valid and let every queued readout come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_readouts.size() != 0) @(posedge i_clk);
    endtask

    // Empty-stack and one-entry underflow, reserved kinds, divide by zero, saturation, rounding
    task automatic test_directed();
        send_token(rpn_pkg::ACT_ADD, 32'h1234_5678);   // empty stack
        send_token(rpn_pkg::ACT_DIV, '0);
        send_token(rpn_pkg::ACT_PUSH, '0);             // zero still pushed
        send_token(rpn_pkg::ACT_MUL, Q_MAX);           // single entry
        send_token(rpn_pkg::ACT_SUB, Q_MIN);
        send_token(rpn_pkg::ACT_DIV, Q_ONE);
        send_token(ACT_RSV5, 32'hFFFF_FFFF);
        send_token(ACT_RSV6, 32'hA5A5_A5A5);
        send_token(ACT_RSV7, 32'h5A5A_5A5A);
        send_token(rpn_pkg::ACT_PUSH, Q_MAX);
        send_token(rpn_pkg::ACT_SUB, '0);              // 0 - max
        send_token(rpn_pkg::ACT_PUSH, '0);
        send_token(rpn_pkg::ACT_DIV, '0);              // divide by zero
        send_token(rpn_pkg::ACT_ADD, '0);
        send_token(rpn_pkg::ACT_PUSH, Q_MIN);
        send_token(rpn_pkg::ACT_ADD, '0);              // negative clamp
        send_token(rpn_pkg::ACT_PUSH, Q_MAX);
        send_token(rpn_pkg::ACT_PUSH, Q_MAX);
        send_token(rpn_pkg::ACT_ADD, '0);              // positive clamp
        send_token(rpn_pkg::ACT_MUL, '0);              // min * max
        send_token(rpn_pkg::ACT_PUSH, Q_NEG_ONE);
        send_token(rpn_pkg::ACT_DIV, '0);              // min / -1 clamps high
        send_token(rpn_pkg::ACT_PUSH, Q_HALF);
        send_token(rpn_pkg::ACT_DIV, '0);
        send_token(rpn_pkg::ACT_PUSH, 32'hFFFF_FFFF);  // tiny negative
        send_token(rpn_pkg::ACT_MUL, '0);
    endtask

    // Fill to the top, push into a full stack, then fold back down to an underflow
    task automatic test_stack_limits();
        while (shadow_depth < rpn_pkg::STACK_DEPTH)
            send_token(rpn_pkg::ACT_PUSH, random_operand());
        send_token(rpn_pkg::ACT_PUSH, '0);
        send_token(rpn_pkg::ACT_PUSH, Q_MAX);
        send_token(rpn_pkg::ACT_MUL, '0);
        send_token(rpn_pkg::ACT_PUSH, Q_ONE);
        while (shadow_depth > 1) send_token(pick_operator(), '0);
        send_token(rpn_pkg::ACT_SUB, '0);
    endtask

    task automatic test_random_expressions();
        send_random(560);
    endtask

    // Back-to-back tokens against an always-ready receiver
    task automatic test_no_idle();
        sender_steady = 1'b1;
        sink_steady = 1'b1;
        send_random(80);
        sender_steady = 1'b0;
        sink_steady = 1'b0;
    endtask

    // Receiver holds off while tokens keep coming, so the input stalls
    task automatic test_output_backpressure();
        sender_steady = 1'b1;
        sink_hold_req = HOLD_CYCLES;
        send_random(20);
        sender_steady = 1'b0;
    endtask

    // Bursts with the sender idle until all readouts are back
    task automatic test_sender_pause();
        repeat (6) begin
            send_random(8);
            drain_results();
        end
    endtask

    // Receiver ready pattern, with the long hold-off on request
    initial begin : result_sink
        int stall;
        forever begin
            @(posedge i_clk);
            if (sink_hold_req > 0) begin
                stall = sink_hold_req;
                sink_hold_req = 0;
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else if (sink_steady) begin
                m_axis_tready <= 1'b1;
            end else begin
                stall = pick_gap();
                if (stall == 0) begin
                    m_axis_tready <= 1'b1;
                end else begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // Compare each result word with the oldest prediction
    always @(posedge i_clk) begin : readout_check
        t_stack_readout want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_readouts.size() == 0) begin
                log_mismatch($sformatf("unexpected result: top %h depth %0d status %0d sat %0d",
                    m_axis_tdata[31:0], m_axis_tdata[rpn_pkg::VALUE_WIDTH +: rpn_pkg::DEPTH_W],
                    m_axis_tuser[1:0], m_axis_tuser[2]));
            end else begin
                want = pending_readouts.pop_front();
                results_checked++;
                if (m_axis_tdata[31:0] !== want.top
                        || m_axis_tdata[rpn_pkg::VALUE_WIDTH +: rpn_pkg::DEPTH_W] !== want.depth
                        || m_axis_tuser[1:0] !== want.status
                        || m_axis_tuser[2] !== want.sat) begin
                    log_mismatch($sformatf(
                        "result %0d: top %h/%h depth %0d/%0d status %0d/%0d sat %0d/%0d (exp/got)",
                        results_checked, want.top, m_axis_tdata[31:0],
                        want.depth, m_axis_tdata[rpn_pkg::VALUE_WIDTH +: rpn_pkg::DEPTH_W],
                        want.status, m_axis_tuser[1:0], want.sat, m_axis_tuser[2]));
                end
            end
        end
    end

    // Watchdog: too long with no word moving on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no word accepted for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_stack_limits();
        test_random_expressions();
        test_no_idle();
        test_output_backpressure();
        test_sender_pause();

        drain_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (pending_readouts.size() != 0)
            log_mismatch($sformatf("%0d results never arrived", pending_readouts.size()));

        $display("Covered %0d results: push %0d, add %0d, sub %0d, mul %0d, div %0d, reserved %0d",
            results_checked, action_tally[rpn_pkg::ACT_PUSH], action_tally[rpn_pkg::ACT_ADD],
            action_tally[rpn_pkg::ACT_SUB], action_tally[rpn_pkg::ACT_MUL],
            action_tally[rpn_pkg::ACT_DIV],
            action_tally[ACT_RSV5] + action_tally[ACT_RSV6] + action_tally[ACT_RSV7]);
        $display("Peak depth %0d, clamped %0d, underflow %0d, full %0d, div-by-zero %0d",
            peak_depth, sat_tally, status_tally[rpn_pkg::ST_UNDERFLOW],
            status_tally[rpn_pkg::ST_FULL], status_tally[rpn_pkg::ST_DIV_ZERO]);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/rpn_pkg.sv
hw/rtl/rpn_div.sv
hw/rtl/rpn_stack_evaluator.sv
tb/testbench.sv
